// ===== src/sstt_pkg.sv =====
`default_nettype none
package sstt_pkg;

  // default pool size
  localparam int NUM_TIMERS_DEF = 32;

  // operation codes
  localparam logic [2:0] OP_ALLOC = 3'd0;
  localparam logic [2:0] OP_FREE  = 3'd1;
  localparam logic [2:0] OP_INIT  = 3'd2;
  localparam logic [2:0] OP_SET   = 3'd3;
  localparam logic [2:0] OP_TICK  = 3'd4;

  // result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_EXPIRY  = 2'd3;

  // timer marks
  localparam logic [1:0] MARK_FREE    = 2'd0;
  localparam logic [1:0] MARK_ALLOC   = 2'd1;
  localparam logic [1:0] MARK_RUNNING = 2'd2;

  localparam logic [31:0] NONE_DUE = 32'hffffffff;

  // broadcast control for the list cells
  typedef struct packed {
    logic start;  // put the scan token at the head
    logic step;   // move the token one cell on
    logic ins;    // insert at the token, shift the tail right
    logic shl;    // pop the head, shift everything left
    logic upd;    // refresh the deadline of entries of one timer
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== src/sorted_software_timer_table_unit.sv =====
`default_nettype none
// Sorted software timer table.
// Input channel s_*: one transaction per command (alloc, free, init, set,
// tick). Output channel m_*: result transactions; every command gives one
// result with tlast high, except a tick that expires k timers, which gives
// k expiry results with tlast on the k-th.
// The running list is a row of cells, one entry each, kept in deadline order.
// Sequence per command: free, init, unknown codes and a refused set go
// straight to the output register; alloc checks one mark per cycle; set
// walks a scan token one cell per cycle to the insertion point; tick
// compares the head deadline and, for each expired timer, pops the head
// and waits for the registered read of the channel and tag memory before
// giving the expiry result.
// The next command is taken in the cycle after the last hand-over.
// Reset (rst, synchronous) frees every timer, empties the list and clears
// the tick count; channel and tag stay undefined until initialised.
// While the receiver holds m_tready low the result stays in the output
// register and the block does no further work.
module sorted_software_timer_table_unit #(
  parameter int NUM_TIMERS = sstt_pkg::NUM_TIMERS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,   // timer_id, delay, channel, tag, zero pad
  input  wire logic [2:0]  s_tuser,   // opcode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [23:0] m_tdata,   // result_timer, out_channel, out_tag, zero pad
  output logic      [1:0]  m_tuser,   // status
  output logic             m_tlast
);
  import sstt_pkg::*;

  localparam int IW  = $clog2(NUM_TIMERS);
  localparam int CAP = (NUM_TIMERS < 32) ? NUM_TIMERS : 32;
  localparam int CW  = $clog2(CAP + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_ALLOC, S_INS, S_TICK, S_POP, S_POP_WAIT, S_OUT
  } state_t;

  state_t          state;
  logic [1:0]      mark [NUM_TIMERS];
  logic [CW-1:0]   count;
  logic [31:0]     tick;
  logic [IW-1:0]   scan;
  logic [IW-1:0]   cur_id;
  logic [31:0]     cur_due;
  logic [IW-1:0]   pop_id;
  logic            pop_last;
  logic            more;
  logic [1:0]      o_status;
  logic [4:0]      o_timer;
  logic [7:0]      o_channel;
  logic [7:0]      o_tag;
  logic            o_last;

  // input fields
  logic [2:0]  in_op;
  logic [4:0]  in_id;
  logic [31:0] in_delay;
  logic [7:0]  in_channel;
  logic [7:0]  in_tag;
  logic        in_ok;
  logic [IW-1:0] in_idw;
  logic        accept;

  assign in_op      = s_tuser;
  assign in_id      = s_tdata[4:0];
  assign in_delay   = s_tdata[36:5];
  assign in_channel = s_tdata[44:37];
  assign in_tag     = s_tdata[52:45];
  assign in_ok      = 32'(in_id) < 32'(NUM_TIMERS);
  assign in_idw     = IW'(in_id);
  assign s_tready   = (state == S_IDLE);
  assign accept     = s_tvalid && s_tready;

  // read address: the head entry while popping, so data is ready in S_POP_WAIT
  logic [IW-1:0] rd_id;
  logic [IW-1:0] c_head_id;
  assign rd_id = (state == S_POP) ? c_head_id : pop_id;

  // channel and tag store
  logic [15:0] ram_rdata;
  sstt_ram #(.WIDTH(16), .DEPTH(NUM_TIMERS)) u_ram (
    .clk   (clk),
    .we    (accept && in_op == OP_INIT && in_ok),
    .waddr (in_idw),
    .wdata ({in_tag, in_channel}),
    .raddr (rd_id),
    .rdata (ram_rdata)
  );

  // head status
  logic [31:0] head_due;
  logic        head_pop;
  logic        next_pop;
  logic [31:0] set_due;

  // broadcast to the cells: straight from the input at the accepting edge
  logic [IW-1:0] bc_id;
  logic [31:0]   bc_due;
  assign bc_id  = (state == S_IDLE) ? in_idw : cur_id;
  assign bc_due = (state == S_IDLE) ? set_due : cur_due;

  // row of list cells, with an empty entry past the tail
  cell_ctrl_t    ctrl;
  logic          c_valid [CAP+1];
  logic [IW-1:0] c_id    [CAP+1];
  logic [31:0]   c_dl    [CAP+1];
  logic          c_tok   [CAP];
  logic [CAP-1:0] c_stop;

  assign c_valid[CAP] = 1'b0;
  assign c_id[CAP]    = '0;
  assign c_dl[CAP]    = '0;
  assign c_head_id    = c_id[0];

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    sstt_cell #(.IW(IW)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .bc_id   (bc_id),
      .bc_due  (bc_due),
      .first   (i == 0),
      .tok_in  ((i == 0) ? 1'b0 : c_tok[(i == 0) ? 0 : i-1]),
      .l_valid ((i == 0) ? 1'b0 : c_valid[(i == 0) ? 0 : i-1]),
      .l_id    (c_id[(i == 0) ? 0 : i-1]),
      .l_dl    (c_dl[(i == 0) ? 0 : i-1]),
      .r_valid (c_valid[i+1]),
      .r_id    (c_id[i+1]),
      .r_dl    (c_dl[i+1]),
      .valid   (c_valid[i]),
      .id      (c_id[i]),
      .dl      (c_dl[i]),
      .tok     (c_tok[i]),
      .stop    (c_stop[i])
    );
  end

  assign head_due = c_valid[0] ? c_dl[0] : NONE_DUE;
  assign head_pop = c_valid[0] && c_dl[0] <= tick;
  assign next_pop = c_valid[1] && c_dl[1] <= tick;
  assign set_due  = in_delay + tick;

  // cell control
  always_comb begin
    ctrl = '0;
    unique case (state)
      S_IDLE: begin
        if (accept && in_op == OP_SET && in_ok && count != CW'(CAP)) begin
          ctrl.start = 1'b1;
          ctrl.upd   = 1'b1;
        end
      end
      S_INS: begin
        ctrl.ins  = |c_stop;
        ctrl.step = !(|c_stop);
      end
      S_POP:   ctrl.shl = head_pop;
      default: ctrl = '0;
    endcase
  end

  // sequencer with registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      tick     <= '0;
      m_tvalid <= 1'b0;
      more     <= 1'b0;
      for (int k = 0; k < NUM_TIMERS; k++) begin
        mark[k] <= MARK_FREE;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            o_status  <= ST_DONE;
            o_timer   <= '0;
            o_channel <= '0;
            o_tag     <= '0;
            o_last    <= 1'b1;
            more      <= 1'b0;
            cur_id    <= in_idw;
            cur_due   <= set_due;
            priority case (1'b1)
              in_op == OP_ALLOC: begin
                scan  <= '0;
                state <= S_ALLOC;
              end
              in_op == OP_FREE: begin
                if (in_ok) begin
                  mark[in_idw] <= MARK_FREE;
                end
                m_tvalid <= 1'b1;
                state    <= S_OUT;
              end
              in_op == OP_SET && in_ok && count != CW'(CAP): begin
                mark[in_idw] <= MARK_RUNNING;
                state        <= S_INS;
              end
              in_op == OP_SET && in_ok: begin
                o_status <= ST_FULL;
                m_tvalid <= 1'b1;
                state    <= S_OUT;
              end
              in_op == OP_TICK: begin
                tick  <= tick + 32'd1;
                state <= S_TICK;
              end
              default: begin
                m_tvalid <= 1'b1;
                state    <= S_OUT;
              end
            endcase
          end
        end
        S_ALLOC: begin
          if (mark[scan] == MARK_FREE) begin
            mark[scan] <= MARK_ALLOC;
            o_timer    <= 5'(scan);
            m_tvalid   <= 1'b1;
            state      <= S_OUT;
          end else if (scan == IW'(NUM_TIMERS - 1)) begin
            o_status <= ST_NO_FREE;
            m_tvalid <= 1'b1;
            state    <= S_OUT;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        S_INS: begin
          if (|c_stop) begin
            count    <= count + 1'b1;
            m_tvalid <= 1'b1;
            state    <= S_OUT;
          end
        end
        S_TICK: begin
          if (head_due > tick) begin
            m_tvalid <= 1'b1;
            state    <= S_OUT;
          end else begin
            state <= S_POP;
          end
        end
        S_POP: begin
          if (head_pop) begin
            pop_id        <= c_id[0];
            pop_last      <= !next_pop;
            mark[c_id[0]] <= MARK_ALLOC;
            count         <= count - 1'b1;
            state         <= S_POP_WAIT;
          end else begin
            m_tvalid <= 1'b1;
            state    <= S_OUT;
          end
        end
        S_POP_WAIT: begin
          o_status  <= ST_EXPIRY;
          o_timer   <= 5'(pop_id);
          o_channel <= ram_rdata[7:0];
          o_tag     <= ram_rdata[15:8];
          o_last    <= pop_last;
          more      <= !pop_last;
          m_tvalid  <= 1'b1;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            state    <= more ? S_POP : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output packing
  assign m_tdata = {3'b000, o_tag, o_channel, o_timer};
  assign m_tuser = o_status;
  assign m_tlast = o_last;

endmodule
`default_nettype wire

// ===== src/sstt_ram.sv =====
`default_nettype none
module sstt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/sstt_cell.sv =====
`default_nettype none
module sstt_cell #(
  parameter int IW = 5
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sstt_pkg::cell_ctrl_t ctrl,
  input  wire logic [IW-1:0]       bc_id,
  input  wire logic [31:0]         bc_due,
  input  wire logic                first,
  input  wire logic                tok_in,
  input  wire logic                l_valid,
  input  wire logic [IW-1:0]       l_id,
  input  wire logic [31:0]         l_dl,
  input  wire logic                r_valid,
  input  wire logic [IW-1:0]       r_id,
  input  wire logic [31:0]         r_dl,
  output logic                     valid,
  output logic      [IW-1:0]       id,
  output logic      [31:0]         dl,
  output logic                     tok,
  output logic                     stop
);
  import sstt_pkg::*;

  logic visited;

  // the token stops where the new entry belongs
  assign stop = tok && (!valid || dl >= bc_due);

  // scan token and visited mark
  always_ff @(posedge clk) begin
    if (rst) begin
      tok     <= 1'b0;
      visited <= 1'b0;
    end else if (ctrl.start) begin
      tok     <= first;
      visited <= 1'b0;
    end else if (ctrl.step) begin
      tok     <= tok_in;
      visited <= visited | tok;
    end
  end

  // entry contents
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.ins) begin
      if (tok) begin
        valid <= 1'b1;
        id    <= bc_id;
        dl    <= bc_due;
      end else if (!visited) begin
        valid <= l_valid;
        id    <= l_id;
        dl    <= l_dl;
      end
    end else if (ctrl.shl) begin
      valid <= r_valid;
      id    <= r_id;
      dl    <= r_dl;
    end else if (ctrl.upd && valid && id == bc_id) begin
      dl <= bc_due;
    end
  end

endmodule
`default_nettype wire
